// ===== rtl/dlps_pkg.sv =====
// ----------------------------------------------------------------------------
// dlps_pkg: shared types and constants for the DDA line pattern stepper
// Default geometry, command and style codes, and the divider handshake.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int C_COORD_BITS = 12;
    localparam int C_FRAC_BITS  = 16;

    // Register index of line_style
    localparam int REG_LINE_STYLE = 0;

    // Input word commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        STYLE_SOLID  = 2'd0,
        STYLE_DASHED = 2'd1,
        STYLE_DOTTED = 2'd2,
        STYLE_NONE   = 2'd3
    } t_style;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/dlps_div.sv =====
// ----------------------------------------------------------------------------
// dlps_div: iterative restoring divider
// One compare/subtract per cycle, FRAC_BITS+1 quotient bits per division.
// The quotient is known to fit FRAC_BITS+1 bits (numerator < den << QW).
// ----------------------------------------------------------------------------
module dlps_div #(
    parameter int COORD_BITS = dlps_pkg::C_COORD_BITS,
    parameter int FRAC_BITS  = dlps_pkg::C_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dlps_pkg::t_div_ctl              i_ctl,
    input  logic [COORD_BITS+FRAC_BITS+1:0] i_num,
    input  logic [COORD_BITS:0]             i_den,
    output dlps_pkg::t_div_sts              o_sts,
    output logic [FRAC_BITS:0]              o_quo
);
    import dlps_pkg::*;

    localparam int NW = COORD_BITS + FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int RW = COORD_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_lo;
    logic [QW-1:0] r_quo;
    logic [RW-1:0] r_den;

    logic [RW:0]   w_trial;
    logic [RW:0]   w_diff;
    logic          w_ge;
    logic          w_step;

    assign w_trial = {r_rem, r_lo[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_step  = r_busy && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (w_step) begin
            r_cnt  <= r_cnt - 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_num[NW-1:QW];
            r_lo  <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (w_step) begin
            r_rem <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_lo  <= {r_lo[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_cnt == '0);
    assign o_quo      = r_quo;

endmodule

// ===== rtl/dda_line_pattern_stepper.sv =====
// ----------------------------------------------------------------------------
// dda_line_pattern_stepper: DDA line rasterizer with a line style
// Loads a line, divides out the per-axis increments, then steps pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_ready) carries one word per command. cmd LOAD
//    takes start and end points; cmd TICK advances the line by one pixel.
//  - Output channel (o_valid / i_ready) returns exactly one word per input
//    word, in order. Load words and ticks past the end return valid_res 0
//    with all other fields zero.
//  - A tick result shows on the output in the cycle after acceptance; ticks may
//    be accepted every cycle while the receiver keeps up.
//  - A load of nonzero length keeps o_ready low while two divisions, x then y,
//    run one after the other through the single restoring divider at one
//    quotient bit per cycle. A zero-length load starts no division.
//  - A finished word sits in the output register; a new word is accepted in
//    the same cycle the old one is taken. A stalled receiver holds o_ready
//    low once the output register is full.
//  - line_style is written through the APB port and read on every tick.
//  - Reset (synchronous, active low) clears the line, the pattern position,
//    the style (solid) and the output valid flag.
// ----------------------------------------------------------------------------
module dda_line_pattern_stepper #(
    parameter int COORD_BITS = dlps_pkg::C_COORD_BITS,
    parameter int FRAC_BITS  = dlps_pkg::C_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input word channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    // output word channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_valid_res,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_draw,
    output logic                         o_last,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dlps_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int AW = C + F + 1;   // accumulator width
    localparam int IW = F + 2;       // signed increment width
    localparam int NW = C + F + 2;   // divider numerator width
    localparam int PW = 5;           // pattern counter width

    // dash: counts below DASH_ON draw, wrap at DASH_LEN; dot: below DOT_ON draw
    localparam logic [PW:0]   DASH_LEN = (PW+1)'(25);
    localparam logic [PW-1:0] DASH_ON  = PW'(21);
    localparam logic [PW-1:0] DOT_ON   = PW'(2);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_XDIV = 4'b0100,
        S_YDIV = 4'b1000
    } t_state;

    // control state
    t_state          r_state, n_state;
    logic [C-1:0]    r_steps_left, n_steps_left;
    logic [PW-1:0]   r_pat, n_pat;
    t_style          r_style;
    logic            r_ovalid, n_ovalid;

    // line payload
    logic signed [AW-1:0] r_acc_x, n_acc_x;
    logic signed [AW-1:0] r_acc_y, n_acc_y;
    logic signed [IW-1:0] r_inc_x, n_inc_x;
    logic signed [IW-1:0] r_inc_y, n_inc_y;
    logic [C-1:0]         r_mag_x, n_mag_x;
    logic [C-1:0]         r_mag_y, n_mag_y;
    logic                 r_neg_x, n_neg_x;
    logic                 r_neg_y, n_neg_y;

    // result payload
    logic                 r_res, n_res;
    logic [C-1:0]         r_px, n_px;
    logic [C-1:0]         r_py, n_py;
    logic                 r_draw, n_draw;
    logic                 r_last, n_last;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic signed [C:0]    w_dx, w_dy;
    logic [C-1:0]         w_mag_dx, w_mag_dy, w_step;

    t_div_ctl             s_div_ctl;
    t_div_sts             s_div_sts;
    logic [NW-1:0]        w_div_num;
    logic [C:0]           w_div_den;
    logic [F:0]           w_quo;
    logic [IW-1:0]        w_quo_ext;

    logic [C-1:0]         w_rnd_x, w_rnd_y;
    logic                 w_pdraw;
    logic [PW-1:0]        w_pat_nx;
    logic [PW:0]          w_pat_inc;
    logic                 w_cfg_wr;

    // round to nearest pixel, ties away from zero, masked to C bits
    function automatic logic [C-1:0] round_pix(input logic [AW-1:0] a);
        logic [AW-1:0] m;
        logic [AW-1:0] s;
        logic [C:0]    r;
        m = a[AW-1] ? -a : a;
        s = m + (AW'(1) << (F - 1));
        r = s[AW-1:F];
        round_pix = a[AW-1] ? C'(-r) : C'(r);
    endfunction

    // ---------------- handshakes ----------------
    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_valid && o_ready;

    // ---------------- load geometry ----------------
    assign w_dx     = {i_end_x[C-1], i_end_x} - {i_start_x[C-1], i_start_x};
    assign w_dy     = {i_end_y[C-1], i_end_y} - {i_start_y[C-1], i_start_y};
    assign w_mag_dx = w_dx[C] ? C'(-w_dx) : C'(w_dx);
    assign w_mag_dy = w_dy[C] ? C'(-w_dy) : C'(w_dy);
    assign w_step   = (w_mag_dx > w_mag_dy) ? w_mag_dx : w_mag_dy;

    // ---------------- shared divider ----------------
    // inc = (|d| * 2^(F+1) + step) / (2 * step), x in PREP, y when x is done
    always_comb begin
        logic [C-1:0] mag;
        mag       = (r_state == S_PREP) ? r_mag_x : r_mag_y;
        w_div_num = NW'({mag, {(F+1){1'b0}}}) + NW'(r_steps_left);
    end
    assign w_div_den       = {r_steps_left, 1'b0};
    assign s_div_ctl.start = (r_state == S_PREP) || ((r_state == S_XDIV) && s_div_sts.done);
    assign w_quo_ext       = {1'b0, w_quo};

    dlps_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_div_ctl),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_sts   (s_div_sts),
        .o_quo   (w_quo)
    );

    // ---------------- line style pattern ----------------
    assign w_pat_inc = {1'b0, r_pat} + 1'b1;
    always_comb begin
        w_pdraw  = 1'b0;
        w_pat_nx = r_pat;
        unique case (r_style)
            STYLE_SOLID: begin
                w_pdraw = 1'b1;
            end
            STYLE_DASHED: begin
                w_pdraw  = (r_pat < DASH_ON);
                w_pat_nx = (w_pat_inc >= DASH_LEN) ? '0 : w_pat_inc[PW-1:0];
            end
            STYLE_DOTTED: begin
                w_pdraw  = (r_pat < DOT_ON);
                w_pat_nx = (r_pat < DOT_ON) ? w_pat_inc[PW-1:0] : '0;
            end
            STYLE_NONE: begin
                w_pdraw = 1'b0;
            end
        endcase
    end

    assign w_rnd_x = round_pix(r_acc_x);
    assign w_rnd_y = round_pix(r_acc_y);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_steps_left = r_steps_left;
        n_pat        = r_pat;
        n_ovalid     = r_ovalid && !i_ready;
        n_acc_x      = r_acc_x;
        n_acc_y      = r_acc_y;
        n_inc_x      = r_inc_x;
        n_inc_y      = r_inc_y;
        n_mag_x      = r_mag_x;
        n_mag_y      = r_mag_y;
        n_neg_x      = r_neg_x;
        n_neg_y      = r_neg_y;
        n_res        = r_res;
        n_px         = r_px;
        n_py         = r_py;
        n_draw       = r_draw;
        n_last       = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_ovalid = 1'b1;
                    n_res    = 1'b0;
                    n_px     = '0;
                    n_py     = '0;
                    n_draw   = 1'b0;
                    n_last   = 1'b0;
                    if (i_cmd == CMD_LOAD) begin
                        n_acc_x      = {i_start_x[C-1], i_start_x, {F{1'b0}}};
                        n_acc_y      = {i_start_y[C-1], i_start_y, {F{1'b0}}};
                        n_mag_x      = w_mag_dx;
                        n_mag_y      = w_mag_dy;
                        n_neg_x      = w_dx[C];
                        n_neg_y      = w_dy[C];
                        n_steps_left = w_step;
                        n_pat        = '0;
                        n_inc_x      = '0;
                        n_inc_y      = '0;
                        if (w_step != '0) begin
                            n_state = S_PREP;
                        end
                    end else if (r_steps_left != '0) begin
                        n_res        = 1'b1;
                        n_px         = w_rnd_x;
                        n_py         = w_rnd_y;
                        n_draw       = w_pdraw;
                        n_last       = (r_steps_left == C'(1));
                        n_pat        = w_pat_nx;
                        n_acc_x      = r_acc_x + AW'(r_inc_x);
                        n_acc_y      = r_acc_y + AW'(r_inc_y);
                        n_steps_left = r_steps_left - 1'b1;
                    end
                end
            end
            S_PREP: begin
                n_state = S_XDIV;
            end
            S_XDIV: begin
                if (s_div_sts.done) begin
                    n_inc_x = r_neg_x ? -w_quo_ext : w_quo_ext;
                    n_state = S_YDIV;
                end
            end
            S_YDIV: begin
                if (s_div_sts.done) begin
                    n_inc_y = r_neg_y ? -w_quo_ext : w_quo_ext;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_steps_left <= '0;
            r_pat        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_steps_left <= n_steps_left;
            r_pat        <= n_pat;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_x <= n_acc_x;
        r_acc_y <= n_acc_y;
        r_inc_x <= n_inc_x;
        r_inc_y <= n_inc_y;
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_res   <= n_res;
        r_px    <= n_px;
        r_py    <= n_py;
        r_draw  <= n_draw;
        r_last  <= n_last;
    end

    assign o_valid     = r_ovalid;
    assign o_valid_res = r_res;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_draw      = r_draw;
    assign o_last      = r_last;

    // ---------------- APB register ----------------
    // paddr[2] selects the register index; only index REG_LINE_STYLE exists
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_LINE_STYLE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style <= STYLE_SOLID;
        end else if (w_cfg_wr) begin
            r_style <= t_style'(pwdata[1:0]);
        end
    end

    assign prdata = (paddr[2] == 1'(REG_LINE_STYLE)) ? 32'(r_style) : '0;

    // ---------------- assertions ----------------
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_cmd == CMD_LOAD) && (w_step == '0))
        |=> ((r_steps_left == '0) && (r_state == S_IDLE)))
        else $error("zero-length load left steps or started a division");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !s_div_sts.busy)
        else $error("divider busy while sequencer idle");

    a_last_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_valid_res)
        else $error("last marker on a word without a step");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XDIV) |=> $stable(r_steps_left))
        else $error("step count changed during division");

    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_sts.done |-> ((r_state == S_XDIV) || (r_state == S_YDIV)))
        else $error("divider finished outside a division state");

endmodule

// ===== sim/dda_line_pattern_stepper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_pattern_stepper_tb: self-checking bench for the DDA line stepper
// Drives load and tick words with random gaps, stalls the result side, sets
// each line style over APB, and checks every result word against an in-bench
// fixed-point model of the rasterizer.
// ----------------------------------------------------------------------------
module dda_line_pattern_stepper_tb;

    import dlps_pkg::*;

    localparam int     COORD_W   = C_COORD_BITS;
    localparam int     FRAC_W    = C_FRAC_BITS;
    localparam longint UNIT      = longint'(1) << FRAC_W;
    localparam longint HALF_UNIT = longint'(1) << (FRAC_W - 1);

    // style pattern geometry
    localparam int DASH_ON     = 21;
    localparam int DASH_PERIOD = 25;
    localparam int DOT_ON      = 2;

    localparam logic [2:0] STYLE_ADDR = 3'(4 * REG_LINE_STYLE);

    localparam int SETTLE_CYCLES = 2 * FRAC_W + 10; // covers one load's divide
    localparam int RUN_LIMIT     = 400_000;
    localparam int HOLD_AT_WORD  = 200;             // result count that starts the long hold
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic                      valid_res;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic                      draw;
        logic                      last;
    } t_pixel_word;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the line state the block should hold, queues the
    // result word each accepted command must produce, and checks results.
    // ------------------------------------------------------------------------
    class dda_pixel_scoreboard;
        t_pixel_word pending_pixels[$];
        longint      acc_x, acc_y, inc_x, inc_y;
        longint      steps_left;
        int unsigned pattern_pos;
        t_style      style;
        int unsigned fails, loads, ticks, steps, drawn, line_ends;

        function new();
            acc_x       = 0;
            acc_y       = 0;
            inc_x       = 0;
            inc_y       = 0;
            steps_left  = 0;
            pattern_pos = 0;
            style       = STYLE_SOLID;
            fails       = 0;
            loads       = 0;
            ticks       = 0;
            steps       = 0;
            drawn       = 0;
            line_ends   = 0;
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // |d| / span in fixed point, nearest, ties away from zero
        function longint increment(longint d, longint span);
            longint q;
            q = ((magnitude(d) << (FRAC_W + 1)) + span) / (2 * span);
            return (d < 0) ? -q : q;
        endfunction

        function longint rounded_pixel(longint a);
            longint r;
            r = (magnitude(a) + HALF_UNIT) >> FRAC_W;
            return (a < 0) ? -r : r;
        endfunction

        function void set_style(t_style s);
            style = s;
        endfunction

        function int unsigned outstanding();
            return pending_pixels.size();
        endfunction

        function void note_command(logic cmd,
                                   logic signed [COORD_W-1:0] sx,
                                   logic signed [COORD_W-1:0] sy,
                                   logic signed [COORD_W-1:0] ex,
                                   logic signed [COORD_W-1:0] ey);
            t_pixel_word w;
            longint      dx, dy, span;
            w = '0;
            if (cmd == CMD_LOAD) begin
                dx          = longint'(ex) - longint'(sx);
                dy          = longint'(ey) - longint'(sy);
                span        = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
                acc_x       = longint'(sx) * UNIT;
                acc_y       = longint'(sy) * UNIT;
                pattern_pos = 0;
                steps_left  = span;
                inc_x       = (span == 0) ? 0 : increment(dx, span);
                inc_y       = (span == 0) ? 0 : increment(dy, span);
                loads++;
            end else begin
                ticks++;
                if (steps_left != 0) begin
                    w.valid_res = 1'b1;
                    w.pixel_x   = COORD_W'(rounded_pixel(acc_x));
                    w.pixel_y   = COORD_W'(rounded_pixel(acc_y));
                    case (style)
                        STYLE_SOLID: begin
                            w.draw = 1'b1;
                        end
                        STYLE_DASHED: begin
                            // a stale count past the period is a gap and wraps
                            w.draw = (pattern_pos < DASH_ON);
                            pattern_pos++;
                            if (pattern_pos >= DASH_PERIOD)
                                pattern_pos = 0;
                        end
                        STYLE_DOTTED: begin
                            w.draw = (pattern_pos < DOT_ON);
                            pattern_pos = w.draw ? pattern_pos + 1 : 0;
                        end
                        default: begin
                            w.draw = 1'b0;
                        end
                    endcase
                    w.last = (steps_left == 1);
                    acc_x += inc_x;
                    acc_y += inc_y;
                    steps_left--;
                    steps++;
                    if (w.draw)
                        drawn++;
                    if (w.last)
                        line_ends++;
                end
            end
            pending_pixels.push_back(w);
        endfunction

        function void field_ok(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                         exp_v, act_v);
                fails++;
            end
        endfunction

        function void check_word(t_pixel_word got);
            t_pixel_word exp_w;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %p", $time, got);
                fails++;
                return;
            end
            exp_w = pending_pixels.pop_front();
            field_ok("valid_res", exp_w.valid_res, got.valid_res);
            field_ok("pixel_x", exp_w.pixel_x, got.pixel_x);
            field_ok("pixel_y", exp_w.pixel_y, got.pixel_y);
            field_ok("draw", exp_w.draw, got.draw);
            field_ok("last", exp_w.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; the driven inputs are known from time zero
    // ------------------------------------------------------------------------
    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      i_valid   = 1'b0;
    logic                      o_ready;
    logic                      i_cmd     = CMD_LOAD;
    logic signed [COORD_W-1:0] i_start_x = '0;
    logic signed [COORD_W-1:0] i_start_y = '0;
    logic signed [COORD_W-1:0] i_end_x   = '0;
    logic signed [COORD_W-1:0] i_end_y   = '0;
    logic                      o_valid;
    logic                      i_ready   = 1'b0;
    logic                      o_valid_res;
    logic signed [COORD_W-1:0] o_pixel_x;
    logic signed [COORD_W-1:0] o_pixel_y;
    logic                      o_draw;
    logic                      o_last;
    logic                      psel      = 1'b0;
    logic                      penable   = 1'b0;
    logic                      pwrite    = 1'b0;
    logic [2:0]                paddr     = '0;
    logic [31:0]               pwdata    = '0;
    logic [31:0]               prdata;
    logic                      pready;

    dda_pixel_scoreboard sb = new();

    bit          quiet      = 1'b0;  // set for the last phase: no idling on either side
    int unsigned words_sent = 0;
    int unsigned cycles     = 0;

    dda_line_pattern_stepper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_valid_res (o_valid_res),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_draw      (o_draw),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: checks each accepted word, stalls in random bursts, and
    // once holds off for a long stretch so the block backs up its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned taken;
        stall_left = 0;
        hold_left  = 0;
        taken      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_word(t_pixel_word'{o_valid_res, o_pixel_x, o_pixel_y, o_draw, o_last});
                taken++;
                if (taken == HOLD_AT_WORD)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Drives a word through the input channel; called just after the clock rises.
    // Valid stays up across back-to-back words.
    task automatic send_word(input logic cmd,
                             input logic signed [COORD_W-1:0] sx,
                             input logic signed [COORD_W-1:0] sy,
                             input logic signed [COORD_W-1:0] ex,
                             input logic signed [COORD_W-1:0] ey);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        do @(posedge i_clk); while (!o_ready);
        sb.note_command(cmd, sx, sy, ex, ey);
        words_sent++;
    endtask

    task automatic load_line(input int sx, input int sy, input int ex, input int ey);
        send_word(CMD_LOAD, COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey));
    endtask

    // tick words carry random endpoint bits; the block must ignore them
    task automatic tick(input int unsigned n);
        repeat (n)
            send_word(CMD_TICK, COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Drop valid and wait for every expected word, plus the divide time.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of line_style, then read it back
    task automatic write_style(input t_style s);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STYLE_ADDR;
        pwdata  <= 32'(s);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_style(s);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[1:0] !== s) begin
            $display("%0t: line_style readback mismatch, expected %0d, actual %0d",
                     $time, s, prdata[1:0]);
            sb.fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // A line of the given span from a random start; the major axis takes the
    // full span. When run out, the ticks may run past the end by up to two.
    task automatic random_line(input int len, input bit run_out);
        int sx, sy, dx, dy, ex, ey, minor;
        sx    = int'($urandom_range(0, 4095)) - 2048;
        sy    = int'($urandom_range(0, 4095)) - 2048;
        minor = int'($urandom_range(0, 2 * len)) - len;
        if ($urandom_range(0, 1)) begin
            dx = $urandom_range(0, 1) ? len : -len;
            dy = minor;
        end else begin
            dx = minor;
            dy = $urandom_range(0, 1) ? len : -len;
        end
        ex = sx + dx;
        ey = sy + dy;
        // fold back into range
        if (ex > 2047 || ex < -2048)
            ex = sx - dx;
        if (ey > 2047 || ey < -2048)
            ey = sy - dy;
        load_line(sx, sy, ex, ey);
        tick(run_out ? len + $urandom_range(0, 2) : $urandom_range(0, len));
    endtask

    // Mostly whole lines of random content; some cut short, some zero length,
    // a few long, and some arbitrary endpoints with a handful of ticks.
    task automatic random_lines(input int unsigned n_words);
        int unsigned goal, pick;
        goal = words_sent + n_words;
        while (words_sent < goal) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                send_word(CMD_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), COORD_W'($urandom));
                tick($urandom_range(0, 3));
            end else if (pick == 2) begin
                random_line(0, 1'b1);
            end else if (pick == 3) begin
                random_line($urandom_range(49, 300), 1'b1);
            end else begin
                random_line($urandom_range(1, 48), pick < 17);
            end
        end
    endtask

    // New style while a line is half done: the old pattern count carries
    // over into the new style, so the phase resumes that line first.
    task automatic style_phase(input t_style s, input int unsigned n_words);
        settle();
        write_style(s);
        tick($urandom_range(1, 8));
        random_lines(n_words);
        random_line(40, 1'b0);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, solid style from reset ---
        tick(1);                                  // nothing loaded yet
        load_line(-2048, -2048, 2047, 2047);      // longest diagonal
        tick(2);
        load_line(2047, -2048, -2048, 2047);      // longest anti-diagonal
        tick(2);
        load_line(-2048, 2047, -2048, 2047);      // zero length
        tick(1);
        load_line(0, 0, -2, 1);                   // y lands on +half: rounds up
        tick(3);                                  // last step, then past the end
        load_line(0, 0, 2, -1);                   // y lands on -half: rounds down
        tick(2);
        load_line(10, -3, 13, -3);                // horizontal
        tick(3);
        load_line(0, 5, 1, -2);                   // steep
        tick(2);

        // --- random phases through every style ---
        style_phase(STYLE_DASHED, 60);
        style_phase(STYLE_DOTTED, 60);
        style_phase(STYLE_NONE, 40);
        style_phase(STYLE_SOLID, 50);
        style_phase(STYLE_DASHED, 50);
        settle();
        quiet = 1'b1;                             // full-rate tail, no idling
        style_phase(STYLE_DOTTED, 60);
        settle();

        $display("Ran %0d loads and %0d ticks: %0d pixels stepped, %0d drawn, %0d lines ended.",
                 sb.loads, sb.ticks, sb.steps, sb.drawn, sb.line_ends);
        $display("All four line styles set, changed mid-line, with a long output hold-off.");
        if (sb.fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
